@@ src/cai_pkg.sv @@
// Shared types, constants and width helpers for the complex integer ALU.
`timescale 1ns / 1ps
package cai_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int RES_WIDTH         = 33;
  localparam int MAX_INT_WIDTH     = 64;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  // Control word that travels down the pipeline next to each beat.
  typedef struct packed {
    logic valid;
    op_e  op;
    logic dz;
  } ctl_t;

  // Internal arithmetic width: room for the widest sum plus sign, at least one
  // bit more than the result, capped at the 64-bit wrap of the arithmetic.
  function automatic int calc_iw(input int w);
    int iw;
    iw = 2 * w + 2;
    if (iw < RES_WIDTH + 1) iw = RES_WIDTH + 1;
    if (iw > MAX_INT_WIDTH) iw = MAX_INT_WIDTH;
    return iw;
  endfunction

endpackage

@@ src/complex_integer_alu.sv @@
// Top level of the complex integer ALU: front end, division cell chain, output.
//
//  Channel   Direction  Handshake               Payload
//  command   in         start_i & !busy_o       opcode_i, a_real_i, a_imag_i, b_real_i, b_imag_i
//  result    out        done_o (one-cycle beat) res_real_o, res_imag_o, div_zero_o
//
// Every beat, whatever its opcode, takes the same path, so results leave in
// command order, one per cycle at full rate. Each beat passes the operand
// capture, product and sum registers, then one division cell per quotient
// bit (IW cells, where IW = max(34, 2 * OPERAND_WIDTH + 2) capped at 64),
// then the output register. busy_o never rises, since the chain takes a new
// beat every cycle. Reset clears all valid flags at once; the receiver
// cannot stall.
`timescale 1ns / 1ps
module complex_integer_alu import cai_pkg::*; #(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [1:0]                      opcode_i,
  input  logic signed [OPERAND_WIDTH-1:0] a_real_i,
  input  logic signed [OPERAND_WIDTH-1:0] a_imag_i,
  input  logic signed [OPERAND_WIDTH-1:0] b_real_i,
  input  logic signed [OPERAND_WIDTH-1:0] b_imag_i,
  output logic                            done_o,
  output logic signed [RES_WIDTH-1:0]     res_real_o,
  output logic signed [RES_WIDTH-1:0]     res_imag_o,
  output logic                            div_zero_o
);

  localparam int IW = calc_iw(OPERAND_WIDTH);

  // Link signals between the front end and the cells; index 0 feeds the first
  // cell and index IW comes out of the last one.
  ctl_t                 ctl_c    [IW+1];
  logic [IW-1:0]        den_c    [IW+1];
  logic [IW-1:0]        mag_re_c [IW+1];
  logic [IW-1:0]        mag_im_c [IW+1];
  logic [IW-1:0]        rem_re_c [IW+1];
  logic [IW-1:0]        rem_im_c [IW+1];
  logic [IW-1:0]        q_re_c   [IW+1];
  logic [IW-1:0]        q_im_c   [IW+1];
  logic                 neg_re_c [IW+1];
  logic                 neg_im_c [IW+1];
  logic [RES_WIDTH-1:0] pass_re_c[IW+1];
  logic [RES_WIDTH-1:0] pass_im_c[IW+1];

  cai_front #(
    .OPERAND_WIDTH(OPERAND_WIDTH),
    .IW           (IW)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .opcode_i (opcode_i),
    .a_real_i (a_real_i),
    .a_imag_i (a_imag_i),
    .b_real_i (b_real_i),
    .b_imag_i (b_imag_i),
    .ctl_o    (ctl_c[0]),
    .den_o    (den_c[0]),
    .mag_re_o (mag_re_c[0]),
    .mag_im_o (mag_im_c[0]),
    .neg_re_o (neg_re_c[0]),
    .neg_im_o (neg_im_c[0]),
    .pass_re_o(pass_re_c[0]),
    .pass_im_o(pass_im_c[0])
  );

  // The partial remainder and quotient start empty for every beat.
  assign rem_re_c[0] = '0;
  assign rem_im_c[0] = '0;
  assign q_re_c[0]   = '0;
  assign q_im_c[0]   = '0;

  // Each cell settles one quotient bit, most significant first, for both the
  // real and the imaginary lane, and hands the beat on to its neighbor.
  for (genvar i = 0; i < IW; i++) begin : g_cell
    cai_div_cell #(
      .IW(IW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl_c[i]),
      .den_i    (den_c[i]),
      .mag_re_i (mag_re_c[i]),
      .mag_im_i (mag_im_c[i]),
      .rem_re_i (rem_re_c[i]),
      .rem_im_i (rem_im_c[i]),
      .q_re_i   (q_re_c[i]),
      .q_im_i   (q_im_c[i]),
      .neg_re_i (neg_re_c[i]),
      .neg_im_i (neg_im_c[i]),
      .pass_re_i(pass_re_c[i]),
      .pass_im_i(pass_im_c[i]),
      .ctl_o    (ctl_c[i+1]),
      .den_o    (den_c[i+1]),
      .mag_re_o (mag_re_c[i+1]),
      .mag_im_o (mag_im_c[i+1]),
      .rem_re_o (rem_re_c[i+1]),
      .rem_im_o (rem_im_c[i+1]),
      .q_re_o   (q_re_c[i+1]),
      .q_im_o   (q_im_c[i+1]),
      .neg_re_o (neg_re_c[i+1]),
      .neg_im_o (neg_im_c[i+1]),
      .pass_re_o(pass_re_c[i+1]),
      .pass_im_o(pass_im_c[i+1])
    );
  end

  ctl_t                 ctl_end;
  logic [IW-1:0]        qs_re, qs_im;
  logic [RES_WIDTH-1:0] res_re_d, res_im_d, res_re_q, res_im_q;
  logic                 done_q, dz_q;

  assign ctl_end = ctl_c[IW];

  // Put the sign back on the quotient magnitudes, then pick the divide result
  // or the add, subtract or multiply result that rode along the chain. A zero
  // divisor forces a zero result.
  always_comb begin
    qs_re = neg_re_c[IW] ? IW'(-q_re_c[IW]) : q_re_c[IW];
    qs_im = neg_im_c[IW] ? IW'(-q_im_c[IW]) : q_im_c[IW];
    if (ctl_end.op == OP_DIV) begin
      if (ctl_end.dz) begin
        res_re_d = '0;
        res_im_d = '0;
      end else begin
        res_re_d = qs_re[RES_WIDTH-1:0];
        res_im_d = qs_im[RES_WIDTH-1:0];
      end
    end else begin
      res_re_d = pass_re_c[IW];
      res_im_d = pass_im_c[IW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      dz_q   <= 1'b0;
    end else begin
      done_q <= ctl_end.valid;
      dz_q   <= ctl_end.valid && ctl_end.dz;
    end
  end

  always_ff @(posedge clk_i) begin
    res_re_q <= res_re_d;
    res_im_q <= res_im_d;
  end

  assign busy_o     = 1'b0;
  assign done_o     = done_q;
  assign div_zero_o = dz_q;
  assign res_real_o = res_re_q;
  assign res_imag_o = res_im_q;

  // A zero-divisor flag only ever comes with a result beat.
  a_dz_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_zero_o |-> done_o) else $error("div_zero_o without done_o");

  // A zero-divisor beat carries a zero result.
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_zero_o |-> (res_real_o == '0) && (res_imag_o == '0))
    else $error("nonzero result on zero divisor");

  // A beat leaving the last cell appears on the result ports next cycle.
  a_chain_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_end.valid |=> done_o) else $error("beat lost at output");

  // No result beat is made up without a beat at the chain end.
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctl_end.valid |=> !done_o) else $error("spurious result beat");

endmodule

@@ src/cai_front.sv @@
// Front end: operand capture, product stage and sum/sign stage.
`timescale 1ns / 1ps
module cai_front import cai_pkg::*; #(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF,
  parameter int IW            = calc_iw(OPERAND_WIDTH_DEF)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [1:0]                      opcode_i,
  input  logic signed [OPERAND_WIDTH-1:0] a_real_i,
  input  logic signed [OPERAND_WIDTH-1:0] a_imag_i,
  input  logic signed [OPERAND_WIDTH-1:0] b_real_i,
  input  logic signed [OPERAND_WIDTH-1:0] b_imag_i,
  output ctl_t                            ctl_o,
  output logic [IW-1:0]                   den_o,
  output logic [IW-1:0]                   mag_re_o,
  output logic [IW-1:0]                   mag_im_o,
  output logic                            neg_re_o,
  output logic                            neg_im_o,
  output logic [RES_WIDTH-1:0]            pass_re_o,
  output logic [RES_WIDTH-1:0]            pass_im_o
);

  localparam int PW = 2 * OPERAND_WIDTH;

  // Stage 1: operand registers.
  logic                            v1_q;
  op_e                             op1_q;
  logic signed [OPERAND_WIDTH-1:0] a_q, b_q, c_q, d_q;

  // Stage 2: products and the part-wise add or subtract.
  logic                  v2_q;
  op_e                   op2_q;
  logic signed [PW-1:0]  ac_q, bd_q, ad_q, bc_q, cc_q, dd_q;
  logic [RES_WIDTH-1:0]  as_re_q, as_im_q;
  logic [RES_WIDTH-1:0]  as_re_d, as_im_d;

  // Stage 3 next values.
  logic [IW-1:0]        ac_x, bd_x, ad_x, bc_x, cc_x, dd_x;
  logic [IW-1:0]        num_re, num_im, mre, mim, den_d;
  logic [RES_WIDTH-1:0] pre_d, pim_d;
  ctl_t                 ctl_d, ctl_q;
  logic [IW-1:0]        den_q, mag_re_q, mag_im_q;
  logic                 neg_re_q, neg_im_q;
  logic [RES_WIDTH-1:0] pass_re_q, pass_im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      ctl_q <= '0;
    end else begin
      v1_q  <= start_i;
      v2_q  <= v1_q;
      ctl_q <= ctl_d;
    end
  end

  always_comb begin
    if (op1_q == OP_SUB) begin
      as_re_d = RES_WIDTH'(a_q) - RES_WIDTH'(c_q);
      as_im_d = RES_WIDTH'(b_q) - RES_WIDTH'(d_q);
    end else begin
      as_re_d = RES_WIDTH'(a_q) + RES_WIDTH'(c_q);
      as_im_d = RES_WIDTH'(b_q) + RES_WIDTH'(d_q);
    end
  end

  always_ff @(posedge clk_i) begin
    op1_q   <= op_e'(opcode_i);
    a_q     <= a_real_i;
    b_q     <= a_imag_i;
    c_q     <= b_real_i;
    d_q     <= b_imag_i;
    op2_q   <= op1_q;
    ac_q    <= PW'(a_q) * PW'(c_q);
    bd_q    <= PW'(b_q) * PW'(d_q);
    ad_q    <= PW'(a_q) * PW'(d_q);
    bc_q    <= PW'(b_q) * PW'(c_q);
    cc_q    <= PW'(c_q) * PW'(c_q);
    dd_q    <= PW'(d_q) * PW'(d_q);
    as_re_q <= as_re_d;
    as_im_q <= as_im_d;
  end

  always_comb begin
    ac_x = IW'(ac_q);
    bd_x = IW'(bd_q);
    ad_x = IW'(ad_q);
    bc_x = IW'(bc_q);
    cc_x = IW'(cc_q);
    dd_x = IW'(dd_q);
    den_d  = cc_x + dd_x;
    num_re = ac_x + bd_x;
    num_im = bc_x - ad_x;
    mre    = num_re[IW-1] ? IW'(-num_re) : num_re;
    mim    = num_im[IW-1] ? IW'(-num_im) : num_im;
    if (op2_q == OP_MUL) begin
      pre_d = RES_WIDTH'(ac_x - bd_x);
      pim_d = RES_WIDTH'(ad_x + bc_x);
    end else begin
      pre_d = as_re_q;
      pim_d = as_im_q;
    end
    ctl_d.valid = v2_q;
    ctl_d.op    = op2_q;
    ctl_d.dz    = (op2_q == OP_DIV) && (den_d == '0);
  end

  always_ff @(posedge clk_i) begin
    den_q     <= den_d;
    mag_re_q  <= mre;
    mag_im_q  <= mim;
    neg_re_q  <= num_re[IW-1];
    neg_im_q  <= num_im[IW-1];
    pass_re_q <= pre_d;
    pass_im_q <= pim_d;
  end

  assign ctl_o     = ctl_q;
  assign den_o     = den_q;
  assign mag_re_o  = mag_re_q;
  assign mag_im_o  = mag_im_q;
  assign neg_re_o  = neg_re_q;
  assign neg_im_o  = neg_im_q;
  assign pass_re_o = pass_re_q;
  assign pass_im_o = pass_im_q;

endmodule

@@ src/cai_div_cell.sv @@
// One restoring-division cell: produces one quotient bit for both lanes.
`timescale 1ns / 1ps
module cai_div_cell import cai_pkg::*; #(
  parameter int IW = calc_iw(OPERAND_WIDTH_DEF)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctl_t                 ctl_i,
  input  logic [IW-1:0]        den_i,
  input  logic [IW-1:0]        mag_re_i,
  input  logic [IW-1:0]        mag_im_i,
  input  logic [IW-1:0]        rem_re_i,
  input  logic [IW-1:0]        rem_im_i,
  input  logic [IW-1:0]        q_re_i,
  input  logic [IW-1:0]        q_im_i,
  input  logic                 neg_re_i,
  input  logic                 neg_im_i,
  input  logic [RES_WIDTH-1:0] pass_re_i,
  input  logic [RES_WIDTH-1:0] pass_im_i,
  output ctl_t                 ctl_o,
  output logic [IW-1:0]        den_o,
  output logic [IW-1:0]        mag_re_o,
  output logic [IW-1:0]        mag_im_o,
  output logic [IW-1:0]        rem_re_o,
  output logic [IW-1:0]        rem_im_o,
  output logic [IW-1:0]        q_re_o,
  output logic [IW-1:0]        q_im_o,
  output logic                 neg_re_o,
  output logic                 neg_im_o,
  output logic [RES_WIDTH-1:0] pass_re_o,
  output logic [RES_WIDTH-1:0] pass_im_o
);

  logic [IW:0]   rs_re, rs_im, df_re, df_im;
  logic          ge_re, ge_im;
  logic [IW-1:0] rem_re_d, rem_im_d;
  ctl_t          ctl_q;

  // Bring down the next dividend bit and try a subtract of the divisor.
  always_comb begin
    rs_re    = {rem_re_i, mag_re_i[IW-1]};
    rs_im    = {rem_im_i, mag_im_i[IW-1]};
    df_re    = rs_re - {1'b0, den_i};
    df_im    = rs_im - {1'b0, den_i};
    ge_re    = rs_re >= {1'b0, den_i};
    ge_im    = rs_im >= {1'b0, den_i};
    rem_re_d = ge_re ? df_re[IW-1:0] : rs_re[IW-1:0];
    rem_im_d = ge_im ? df_im[IW-1:0] : rs_im[IW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    den_o     <= den_i;
    mag_re_o  <= {mag_re_i[IW-2:0], 1'b0};
    mag_im_o  <= {mag_im_i[IW-2:0], 1'b0};
    rem_re_o  <= rem_re_d;
    rem_im_o  <= rem_im_d;
    q_re_o    <= {q_re_i[IW-2:0], ge_re};
    q_im_o    <= {q_im_i[IW-2:0], ge_im};
    neg_re_o  <= neg_re_i;
    neg_im_o  <= neg_im_i;
    pass_re_o <= pass_re_i;
    pass_im_o <= pass_im_i;
  end

  assign ctl_o = ctl_q;

endmodule
